// ----- design/mbe_pkg.sv -----
// Shared types, constants and controller states for the fixed-point Mandelbrot
// escape-time block. No dependencies; every other design file imports this package.

package mbe_pkg;

  // Field widths fixed by the interface.
  localparam int COORD_BITS   = 12;
  localparam int COUNT_BITS   = 16;
  localparam int DIM_BITS     = 13;
  localparam int SUM_BITS     = 64;

  // Fixed-point arithmetic widths.
  localparam int Z_BITS       = 24;  // |z| stays below 8.4e6 at every point of the loop
  localparam int SQ_BITS      = 2 * Z_BITS;
  localparam int DIV_W        = 42;  // any quotient input stays below 2^42
  localparam int DSR_W        = 20;  // divisor width, holds 1000000
  localparam int DIV_STEP     = 6;   // quotient bits produced per cycle
  localparam int DIV_CYCLES   = DIV_W / DIV_STEP;
  localparam int DIV_CNT_W    = $clog2(DIV_CYCLES + 1);

  // Scaling constants of the mapping and the iteration.
  localparam logic [DSR_W-1:0] FX_ONE  = 20'd1000000;
  localparam logic [5:0]       RE_MUL  = 6'd35;
  localparam logic [DSR_W-1:0] RE_DIV  = 20'd10;
  localparam logic signed [Z_BITS:0] RE_OFFSET = 25'sd2500000;  // 25 * 1e6 / 10
  localparam logic signed [Z_BITS-1:0] IM_OFFSET = 24'sd1000000;
  localparam logic signed [SQ_BITS:0] ESC_BOUND = 49'sd4000000000000;

  // Register map.
  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_MAX_ITER = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]   image_width;
    logic [DIM_BITS-1:0]   image_height;
    logic [COUNT_BITS-1:0] max_iterations;
  } cfg_t;

  // Channel payloads.
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  restart;
  } pixel_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] iteration_count;
    logic [SUM_BITS-1:0]   running_checksum;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;    // capture pixel, start both coordinate divisions
    logic scale;   // latch ci, start the real-axis divide by ten
    logic init;    // latch cr, clear z and the count
    logic square;  // register the three products of z
    logic zdiv;    // start both divisions by the fixed-point scale
    logic update;  // write the new z and bump the count
    logic finish;  // fold the count into the checksum and post the result
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_busy;
    logic stop;
    logic out_free;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_SCALE,
    ST_SQUARE,
    ST_TEST,
    ST_ZDIV,
    ST_FINISH
  } state_t;

endpackage

// ----- design/mbe_divider.sv -----
// Sequential unsigned divider, several quotient bits per cycle by restoring steps.
// Depends on mbe_pkg for its widths and step count.

module mbe_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mbe_pkg::DIV_W-1:0] dividend,
  input  logic [mbe_pkg::DSR_W-1:0] divisor,
  output logic [mbe_pkg::DIV_W-1:0] quotient,
  output logic                      busy
);
  import mbe_pkg::*;

  logic [DIV_W-1:0]     acc;
  logic [DSR_W-1:0]     rem;
  logic [DSR_W-1:0]     dsr;
  logic [DIV_CNT_W-1:0] cnt;

  logic [DIV_W-1:0]     acc_next;
  logic [DSR_W-1:0]     rem_next;

  // One cycle: DIV_STEP times, shift in a dividend bit and subtract when it fits.
  always_comb begin
    logic [DSR_W:0] trial;
    acc_next = acc;
    rem_next = rem;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial = {rem_next, acc_next[DIV_W-1]};
      if (trial >= {1'b0, dsr}) begin
        trial    = trial - {1'b0, dsr};
        acc_next = {acc_next[DIV_W-2:0], 1'b1};
      end else begin
        acc_next = {acc_next[DIV_W-2:0], 1'b0};
      end
      rem_next = trial[DSR_W-1:0];
    end
  end

  // The step counter is control state; the operand registers need no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CNT_W'(DIV_CYCLES);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (cnt != '0) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign quotient = acc;
  assign busy     = (cnt != '0);

endmodule

// ----- design/mbe_datapath.sv -----
// Datapath: coordinate mapping, z = z*z + c iteration, checksum and result register.
// Depends on mbe_pkg and instantiates two mbe_divider units.

module mbe_datapath (
  input  logic                clk,
  input  logic                rst,
  input  mbe_pkg::cfg_t       cfg,
  input  mbe_pkg::pixel_t     pixel,
  input  mbe_pkg::dp_cmd_t    cmd,
  output mbe_pkg::dp_status_t status,
  input  logic                result_stall,
  output logic                result_valid,
  output mbe_pkg::result_t    result
);
  import mbe_pkg::*;

  // Iteration state.
  logic                         restart;
  logic signed [Z_BITS-1:0]     cr;
  logic signed [Z_BITS-1:0]     ci;
  logic signed [Z_BITS-1:0]     zr;
  logic signed [Z_BITS-1:0]     zi;
  logic        [COUNT_BITS-1:0] iter_n;
  logic signed [SQ_BITS-1:0]    sq_rr;
  logic signed [SQ_BITS-1:0]    sq_ii;
  logic signed [SQ_BITS-1:0]    sq_ri;
  logic                         sign_r;
  logic                         sign_i;
  logic        [SUM_BITS-1:0]   checksum;

  // Divider connections.
  logic             re_start, im_start;
  logic [DIV_W-1:0] re_dividend, im_dividend;
  logic [DSR_W-1:0] re_divisor, im_divisor;
  logic [DIV_W-1:0] re_quot, im_quot;
  logic             re_busy, im_busy;

  // Coordinate clamp; a zero dimension counts as one.
  logic [DIM_BITS-1:0]   w_eff, h_eff, x_lim, y_lim;
  logic [COORD_BITS-1:0] x_clamp, y_clamp;
  logic [31:0]           x_scaled, y_scaled;
  logic [25:0]           re_scaled;

  assign w_eff = (cfg.image_width  == '0) ? DIM_BITS'(1) : cfg.image_width;
  assign h_eff = (cfg.image_height == '0) ? DIM_BITS'(1) : cfg.image_height;
  assign x_lim = w_eff - DIM_BITS'(1);
  assign y_lim = h_eff - DIM_BITS'(1);
  assign x_clamp = ({1'b0, pixel.pixel_x} > x_lim) ? x_lim[COORD_BITS-1:0] : pixel.pixel_x;
  assign y_clamp = ({1'b0, pixel.pixel_y} > y_lim) ? y_lim[COORD_BITS-1:0] : pixel.pixel_y;
  assign x_scaled  = x_clamp * FX_ONE;
  assign y_scaled  = y_clamp * FX_ONE;
  assign re_scaled = re_quot[DSR_W-1:0] * RE_MUL;

  // Products of z, magnitude and the escape test.
  logic signed [SQ_BITS:0] sum_sq, diff_sq, twice_ri;
  logic        [DIV_W-1:0] diff_mag, twice_mag;

  always_comb begin
    sum_sq   = SQ_BITS'(1)'(0);
    sum_sq   = (SQ_BITS+1)'(sq_rr) + (SQ_BITS+1)'(sq_ii);
    diff_sq  = (SQ_BITS+1)'(sq_rr) - (SQ_BITS+1)'(sq_ii);
    twice_ri = (SQ_BITS+1)'(sq_ri) <<< 1;
    diff_mag  = diff_sq[SQ_BITS]  ? DIV_W'(-diff_sq)  : DIV_W'(diff_sq);
    twice_mag = twice_ri[SQ_BITS] ? DIV_W'(-twice_ri) : DIV_W'(twice_ri);
  end

  // Operand selection for the two dividers.
  always_comb begin
    re_dividend = {{(DIV_W-32){1'b0}}, x_scaled};
    re_divisor  = {{(DSR_W-DIM_BITS){1'b0}}, w_eff};
    im_dividend = {{(DIV_W-32){1'b0}}, y_scaled};
    im_divisor  = {{(DSR_W-DIM_BITS){1'b0}}, h_eff};
    if (cmd.scale) begin
      re_dividend = {{(DIV_W-26){1'b0}}, re_scaled};
      re_divisor  = RE_DIV;
    end
    if (cmd.zdiv) begin
      re_dividend = diff_mag;
      re_divisor  = FX_ONE;
      im_dividend = twice_mag;
      im_divisor  = FX_ONE;
    end
  end

  assign re_start = cmd.load | cmd.scale | cmd.zdiv;
  assign im_start = cmd.load | cmd.zdiv;

  mbe_divider u_div_re (
    .clk      (clk),
    .rst      (rst),
    .start    (re_start),
    .dividend (re_dividend),
    .divisor  (re_divisor),
    .quotient (re_quot),
    .busy     (re_busy)
  );

  mbe_divider u_div_im (
    .clk      (clk),
    .rst      (rst),
    .start    (im_start),
    .dividend (im_dividend),
    .divisor  (im_divisor),
    .quotient (im_quot),
    .busy     (im_busy)
  );

  // Point of the plane and the next z, truncated toward zero by sign and magnitude.
  logic signed [Z_BITS:0] cr_wide, zr_wide, zi_wide, qr_s, qi_s;
  logic signed [Z_BITS-1:0] ci_next;

  always_comb begin
    cr_wide = $signed({3'b0, re_quot[Z_BITS-3:0]}) - RE_OFFSET;
    ci_next = $signed({3'b0, im_quot[DSR_W-1:0], 1'b0}) - IM_OFFSET;
    qr_s    = sign_r ? -$signed({2'b0, re_quot[Z_BITS-2:0]})
                     :  $signed({2'b0, re_quot[Z_BITS-2:0]});
    qi_s    = sign_i ? -$signed({2'b0, im_quot[Z_BITS-2:0]})
                     :  $signed({2'b0, im_quot[Z_BITS-2:0]});
    zr_wide = qr_s + (Z_BITS+1)'(cr);
    zi_wide = qi_s + (Z_BITS+1)'(ci);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      restart <= pixel.restart;
    end
    if (cmd.scale) begin
      ci <= ci_next;
    end
    if (cmd.init) begin
      cr     <= cr_wide[Z_BITS-1:0];
      zr     <= '0;
      zi     <= '0;
      iter_n <= '0;
    end
    if (cmd.square) begin
      sq_rr <= zr * zr;
      sq_ii <= zi * zi;
      sq_ri <= zr * zi;
    end
    if (cmd.zdiv) begin
      sign_r <= diff_sq[SQ_BITS];
      sign_i <= twice_ri[SQ_BITS];
    end
    if (cmd.update) begin
      zr     <= zr_wide[Z_BITS-1:0];
      zi     <= zi_wide[Z_BITS-1:0];
      iter_n <= iter_n + COUNT_BITS'(1);
    end
  end

  // Checksum and the result register that parts the output side.
  logic [SUM_BITS-1:0] checksum_next;

  assign checksum_next = (restart ? '0 : checksum) + SUM_BITS'(iter_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        checksum     <= checksum_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.iteration_count  <= iter_n;
      result.running_checksum <= checksum_next;
    end
  end

  assign status.div_busy = re_busy | im_busy;
  assign status.stop     = (iter_n >= cfg.max_iterations) || (sum_sq > ESC_BOUND);
  assign status.out_free = !result_valid || !result_stall;

  // The z division is only started once both dividers have finished.
  a_zdiv_idle : assert property (@(posedge clk) disable iff (rst)
    cmd.zdiv |-> !re_busy && !im_busy)
    else $error("divider started while still busy");

  // A waiting result is never overwritten.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !result_valid || !result_stall)
    else $error("result overwritten before transfer");

  // Each update adds exactly one iteration.
  a_count_step : assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> iter_n == COUNT_BITS'($past(iter_n) + COUNT_BITS'(1)))
    else $error("iteration count did not advance by one");

  // The count posted at finish never passes the limit.
  a_count_limit : assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> iter_n <= cfg.max_iterations)
    else $error("iteration count above limit");

endmodule

// ----- design/mbe_ctrl.sv -----
// Controller state machine sequencing mapping, iteration and result posting.
// Depends on mbe_pkg for states, commands and status.

module mbe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  input  mbe_pkg::dp_status_t status,
  output mbe_pkg::dp_cmd_t    cmd
);
  import mbe_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next  = state;
    cmd         = '0;
    pixel_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        pixel_stall = 1'b0;
        if (pixel_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MAP;
        end
      end
      ST_MAP: begin
        if (!status.div_busy) begin
          cmd.scale  = 1'b1;
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (!status.div_busy) begin
          cmd.init   = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_TEST;
      end
      ST_TEST: begin
        if (status.stop) begin
          state_next = ST_FINISH;
        end else begin
          cmd.zdiv   = 1'b1;
          state_next = ST_ZDIV;
        end
      end
      ST_ZDIV: begin
        if (!status.div_busy) begin
          cmd.update = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/mandelbrot_escape_fixed_point.sv -----
// Top level: configuration registers on the APB-style port, controller and datapath.
// Each iteration registers the products of z, tests for escape, then runs both dividers.
// One pixel is in flight at a time; the next transfer is taken as soon as the result is
// posted, and a stalled output holds back the posting.
// Synchronous reset clears control state and the checksum and loads 128/128/100.

module mandelbrot_escape_fixed_point (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             pixel_valid,
  output logic             pixel_stall,
  input  mbe_pkg::pixel_t  pixel,
  output logic             result_valid,
  input  logic             result_stall,
  output mbe_pkg::result_t result
);
  import mbe_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  reg_idx_t   reg_idx;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel & penable & pwrite & pready;

  // Register writes; addresses past the last register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width    <= DIM_BITS'(128);
      cfg.image_height   <= DIM_BITS'(128);
      cfg.max_iterations <= COUNT_BITS'(100);
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_WIDTH:    cfg.image_width    <= pwdata[DIM_BITS-1:0];
        REG_HEIGHT:   cfg.image_height   <= pwdata[DIM_BITS-1:0];
        REG_MAX_ITER: cfg.max_iterations <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:    prdata = {{(32-DIM_BITS){1'b0}}, cfg.image_width};
      REG_HEIGHT:   prdata = {{(32-DIM_BITS){1'b0}}, cfg.image_height};
      REG_MAX_ITER: prdata = {{(32-COUNT_BITS){1'b0}}, cfg.max_iterations};
      default:      prdata = '0;
    endcase
  end

  mbe_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .status      (status),
    .cmd         (cmd)
  );

  mbe_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pixel        (pixel),
    .cmd          (cmd),
    .status       (status),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ----- test/mandelbrot_escape_fixed_point_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the fixed-point Mandelbrot escape-time block: directed
// corner pixels and register settings, then random phases with idling and back-pressure.
// Depends only on mbe_pkg and the mandelbrot_escape_fixed_point design.

module mandelbrot_escape_fixed_point_test;
  import mbe_pkg::*;

  // Fixed-point mapping and escape constants, scale 1e6.
  localparam longint SCALE      = 1000000;
  localparam longint REAL_MUL   = 35;
  localparam longint REAL_DIV   = 10;
  localparam longint REAL_SHIFT = 2500000;
  localparam longint ESCAPE_R2  = 64'sd4000000000000;

  localparam int HOLD_CYCLES   = 1500;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 200;
  localparam int DRAIN_CYCLES  = 40;
  localparam int QUIET_PHASE   = 3;
  localparam int HOLD_PHASE    = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  pixel_t      pixel = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;

  // Shadow copy of the registers and the checksum.
  logic [DIM_BITS-1:0]   width_reg = 13'd128;
  logic [DIM_BITS-1:0]   height_reg = 13'd128;
  logic [COUNT_BITS-1:0] iter_limit_reg = 16'd100;
  logic [SUM_BITS-1:0]   checksum_model = '0;

  pixel_t  pixel_backlog[$];
  result_t escape_results_due[$];

  int     idle_pct = 35;
  logic   hold_start = 1'b0;
  int     hold_left = 0;
  longint cycle_count = 0;
  longint cycle_limit = 100000;
  int     fail_count = 0;
  int     pixels_sent = 0;
  int     results_checked = 0;
  int     restarts_sent = 0;
  int     settings_applied = 0;

  mandelbrot_escape_fixed_point uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Maps a pixel to c, runs the escape loop and folds the count into the checksum.
  function automatic void predict_escape(input pixel_t px);
    longint unsigned cols, rows, col, row, steps;
    longint re_c, im_c, z_re, z_im, next_re;
    result_t due;
    cols = (width_reg == 0) ? 1 : width_reg;
    rows = (height_reg == 0) ? 1 : height_reg;
    col = px.pixel_x;
    row = px.pixel_y;
    if (col > cols - 1) col = cols - 1;
    if (row > rows - 1) row = rows - 1;
    re_c = longint'((col * SCALE) / cols) * REAL_MUL / REAL_DIV - REAL_SHIFT;
    im_c = longint'((row * SCALE) / rows) * 2 - SCALE;
    z_re = 0;
    z_im = 0;
    steps = 0;
    while (steps < iter_limit_reg && z_re * z_re + z_im * z_im <= ESCAPE_R2) begin
      next_re = (z_re * z_re - z_im * z_im) / SCALE + re_c;
      z_im = (2 * z_re * z_im) / SCALE + im_c;
      z_re = next_re;
      steps++;
    end
    if (px.restart) checksum_model = '0;
    checksum_model += steps[COUNT_BITS-1:0];
    due.iteration_count = steps[COUNT_BITS-1:0];
    due.running_checksum = checksum_model;
    escape_results_due.push_back(due);
  endfunction

  // Queues one pixel and widens the timeout by its worst-case cost.
  function automatic void queue_pixel(input int col, input int row, input bit clear_sum);
    pixel_t px;
    px.pixel_x = col[COORD_BITS-1:0];
    px.pixel_y = row[COORD_BITS-1:0];
    px.restart = clear_sum;
    pixel_backlog.push_back(px);
    cycle_limit += 4 * (240 + 10 * longint'(iter_limit_reg));
    if (clear_sum) restarts_sent++;
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(9))
      0: return 0;
      1: return 4096;
      2: return 8191;
      3, 4: return $urandom_range(16, 1);
      default: return $urandom_range(4096, 1);
    endcase
  endfunction

  // One APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WIDTH:    width_reg = value[DIM_BITS-1:0];
      REG_HEIGHT:   height_reg = value[DIM_BITS-1:0];
      REG_MAX_ITER: iter_limit_reg = value[COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int cols, input int rows, input int iter_cap);
    write_reg(REG_WIDTH, cols);
    write_reg(REG_HEIGHT, rows);
    write_reg(REG_MAX_ITER, iter_cap);
    settings_applied++;
    @(negedge clk);
  endtask

  // Returns once every queued pixel has been transferred and its result checked.
  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_backlog.size() != 0 || pixel_valid || escape_results_due.size() != 0);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Long receiver hold-off, started by a one-cycle pulse.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Pixel driver: predicts on each transfer, then offers the next pixel or idles.
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        predict_escape(pixel);
        pixels_sent++;
      end
      if (!pixel_valid || !pixel_stall) begin
        if (pixel_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          pixel <= pixel_backlog.pop_front();
          pixel_valid <= 1'b1;
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each transfer with the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t due;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (escape_results_due.size() == 0) begin
          $error("unexpected result: iteration_count %0d running_checksum %0d",
                 result.iteration_count, result.running_checksum);
          fail_count++;
        end else begin
          due = escape_results_due.pop_front();
          if (result.iteration_count !== due.iteration_count) begin
            $error("iteration_count expected %0d actual %0d",
                   due.iteration_count, result.iteration_count);
            fail_count++;
          end
          if (result.running_checksum !== due.running_checksum) begin
            $error("running_checksum expected %0d actual %0d",
                   due.running_checksum, result.running_checksum);
            fail_count++;
          end
          results_checked++;
        end
      end
      result_stall <= (hold_left != 0) || ($urandom_range(99) < idle_pct);
    end
  end

  initial begin
    while (cycle_count < cycle_limit) @(posedge clk);
    $display("[mandelbrot_escape_fixed_point] ERROR");
    $finish;
  end

  initial begin
    int cols, rows, iter_cap, span_x, span_y, phase, k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: corners, clamped coordinates, an interior point, restarts.
    queue_pixel(0, 0, 1);
    queue_pixel(4095, 4095, 0);
    queue_pixel(127, 127, 0);
    queue_pixel(64, 64, 0);
    queue_pixel(128, 0, 0);
    queue_pixel(0, 4095, 1);
    queue_pixel(4095, 0, 0);
    queue_pixel(64, 32, 0);
    queue_pixel(32, 64, 0);
    queue_pixel(100, 60, 0);
    queue_pixel(2048, 1, 0);
    wait_idle();

    // Zero dimensions behave as one column and one row.
    set_config(0, 0, 1);
    queue_pixel(0, 0, 0);
    queue_pixel(4095, 4095, 1);
    queue_pixel(1, 2, 0);
    wait_idle();

    // Zero iteration limit at the largest listed dimensions.
    set_config(4096, 4096, 0);
    queue_pixel(4095, 4095, 0);
    queue_pixel(2048, 2048, 1);
    queue_pixel(0, 0, 0);
    wait_idle();

    // Highest limit with oversized dimensions; left-edge points escape after the first iteration.
    set_config(8191, 8191, 65535);
    queue_pixel(0, 0, 0);
    queue_pixel(0, 4095, 0);
    queue_pixel(0, 2048, 1);
    wait_idle();

    // A tiny image.
    set_config(3, 2, 50);
    queue_pixel(2, 1, 0);
    queue_pixel(4095, 4095, 0);
    queue_pixel(1, 0, 1);
    queue_pixel(0, 1, 0);
    wait_idle();

    // Random phases, each with its own settings.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      cols = pick_dim();
      rows = pick_dim();
      case ($urandom_range(9))
        0: iter_cap = 0;
        1: iter_cap = $urandom_range(128, 49);
        default: iter_cap = $urandom_range(48, 1);
      endcase
      set_config(cols, rows, iter_cap);
      idle_pct = (phase == QUIET_PHASE) ? 0 : 35;
      span_x = (cols == 0) ? 0 : ((cols > 4096) ? 4095 : cols - 1);
      span_y = (rows == 0) ? 0 : ((rows > 4096) ? 4095 : rows - 1);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        queue_pixel(($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(span_x),
                    ($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(span_y),
                    $urandom_range(19) == 0);
      end
      // Stall the output for a long stretch while pixels keep coming.
      if (phase == HOLD_PHASE) begin
        hold_start = 1'b1;
        @(negedge clk);
        hold_start = 1'b0;
      end
      wait_idle();
    end

    idle_pct = 35;
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d pixel transfers (%0d restarts) over %0d register settings, %0d results checked.",
             pixels_sent, restarts_sent, settings_applied, results_checked);
    if (fail_count == 0) begin
      $display("[mandelbrot_escape_fixed_point] OK");
    end else begin
      $display("[mandelbrot_escape_fixed_point] ERROR");
    end
    $finish;
  end

endmodule
